// ----- rtl/tvk_pkg.sv -----
// ----------------------------------------------------------------------------
// tvk_pkg
// Shared widths, register indexes, reset values and helpers for the
// two-axis velocity filter.
// ----------------------------------------------------------------------------
package tvk_pkg;

	localparam int DATA_W    = 32;
	localparam int FRAC      = 16;
	localparam int GAIN_BITS = 16;
	localparam int DT_W      = 24;
	localparam int MCAND_W   = DATA_W + 2;
	localparam int MULT_W    = DT_W;
	localparam int PROD_W    = MCAND_W + MULT_W;
	localparam int DIV_W     = DATA_W + 2;
	localparam int SUM_W     = PROD_W - FRAC + 1;
	localparam int CNT_W     = 5;
	localparam int IDX_W     = 3;

	localparam logic [IDX_W-1:0] REG_PN_X   = 3'd0;
	localparam logic [IDX_W-1:0] REG_PN_Y   = 3'd1;
	localparam logic [IDX_W-1:0] REG_MN_X   = 3'd2;
	localparam logic [IDX_W-1:0] REG_MN_Y   = 3'd3;
	localparam logic [IDX_W-1:0] REG_BIAS_X = 3'd4;
	localparam logic [IDX_W-1:0] REG_BIAS_Y = 3'd5;

	localparam logic [DATA_W-1:0] RST_PN   = 32'd42598;
	localparam logic [DATA_W-1:0] RST_MN   = 32'd65536;
	localparam logic [DATA_W-1:0] RST_BIAS_X = 32'hFFFE_8000;
	localparam logic [DATA_W-1:0] RST_BIAS_Y = 32'hFFFF_CCCD;

	localparam logic [GAIN_BITS-1:0] GAIN_MAX = '1;

	typedef struct packed {
		logic             start;
		logic             div;
		logic [CNT_W-1:0] steps;
	} tvk_cmd_t;

	function automatic logic signed [DATA_W-1:0] sat_word(input logic signed [SUM_W-1:0] x);
		logic signed [SUM_W-1:0] hi;
		logic signed [SUM_W-1:0] lo;
		hi = SUM_W'($signed({1'b0, {(DATA_W-1){1'b1}}}));
		lo = -hi - SUM_W'(1);
		if (x > hi)
			return hi[DATA_W-1:0];
		else if (x < lo)
			return lo[DATA_W-1:0];
		else
			return x[DATA_W-1:0];
	endfunction

endpackage

// ----- rtl/two_axis_velocity_kalman_core.sv -----
// ----------------------------------------------------------------------------
// two_axis_velocity_kalman_core
// Pair of scalar velocity filters fusing optical flow and acceleration.
// ----------------------------------------------------------------------------
// Usage: an input word (flow, acceleration per axis and a time step) is taken
// on in_valid/in_ready. The x axis is processed first, then the y axis, each
// by one shared bit-serial unit: a 24-step multiply for the prediction, a
// 16-step divide for the gain, then 16- and 17-step multiplies for the
// velocity and covariance updates. The divide is skipped when the gain needs
// none (zero measurement noise). A new input word is taken only while the
// block is idle, never during processing. The result word sits in an output
// register until out_ready; the next input word is taken meanwhile, and its
// processing holds in its last step until the output register is free.
// Configuration writes (cfg_valid/cfg_ready, always ready) set noises and
// biases by index and are to be made while the block is idle, which the
// block itself does not enforce; unknown indexes are ignored. Reset clears
// velocity and covariance state and loads the default noises and biases.
// ----------------------------------------------------------------------------
module two_axis_velocity_kalman_core
	import tvk_pkg::*;
(
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      cfg_valid,
	output logic                      cfg_ready,
	input  logic [IDX_W-1:0]          cfg_index,
	input  logic [DATA_W-1:0]         cfg_data,
	input  logic                      in_valid,
	output logic                      in_ready,
	input  logic signed [DATA_W-1:0]  flow_x,
	input  logic signed [DATA_W-1:0]  flow_y,
	input  logic signed [DATA_W-1:0]  accel_x,
	input  logic signed [DATA_W-1:0]  accel_y,
	input  logic [DT_W-1:0]           time_step,
	output logic                      out_valid,
	input  logic                      out_ready,
	output logic signed [DATA_W-1:0]  vel_x_out,
	output logic signed [DATA_W-1:0]  vel_y_out
);

	localparam logic [3:0] S_IDLE  = 4'd0;
	localparam logic [3:0] S_PMUL  = 4'd1;
	localparam logic [3:0] S_PWAIT = 4'd2;
	localparam logic [3:0] S_DIV   = 4'd3;
	localparam logic [3:0] S_DWAIT = 4'd4;
	localparam logic [3:0] S_VMUL  = 4'd5;
	localparam logic [3:0] S_VWAIT = 4'd6;
	localparam logic [3:0] S_CMUL  = 4'd7;
	localparam logic [3:0] S_CWAIT = 4'd8;
	localparam logic [3:0] S_OUT   = 4'd9;

	logic [3:0]                state_q;
	logic                      axis_q;
	logic                      out_valid_q;

	logic [DATA_W-1:0]         pnx_q, pny_q, mnx_q, mny_q;
	logic signed [DATA_W-1:0]  biasx_q, biasy_q;
	logic signed [DATA_W-1:0]  velx_q, vely_q;
	logic [DATA_W-1:0]         covx_q, covy_q;

	logic signed [DATA_W-1:0]  flowx_q, flowy_q, accx_q, accy_q;
	logic [DT_W-1:0]           dt_q;
	logic signed [DATA_W-1:0]  pred_q, vn_q, resx_q, resy_q;
	logic [DATA_W-1:0]         pn_q;
	logic signed [DATA_W:0]    diff_q;
	logic [GAIN_BITS-1:0]      g_q;
	logic signed [DATA_W-1:0]  outx_q, outy_q;

	logic signed [DATA_W-1:0]  vel_s, flow_s, acc_s, bias_s;
	logic [DATA_W-1:0]         cov_s, q_s, r_s;
	logic [DATA_W:0]           pq_sum;
	logic [DIV_W-1:0]          den_sum;
	logic [GAIN_BITS:0]        k_val;
	logic signed [SUM_W-1:0]   prod_hi;
	logic signed [DATA_W-1:0]  vn_sat;

	tvk_cmd_t                  cmd;
	logic signed [MCAND_W-1:0] op_a;
	logic [MULT_W-1:0]         op_b;
	logic                      u_done;
	logic signed [PROD_W-1:0]  u_prod;
	logic [GAIN_BITS-1:0]      u_quo;

	tvk_serial_unit u_unit (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd),
		.a      (op_a),
		.b      (op_b),
		.den    (den_sum),
		.done   (u_done),
		.prod   (u_prod),
		.quo    (u_quo)
	);

	// per-axis operand select
	assign vel_s  = axis_q ? vely_q  : velx_q;
	assign cov_s  = axis_q ? covy_q  : covx_q;
	assign flow_s = axis_q ? flowy_q : flowx_q;
	assign acc_s  = axis_q ? accy_q  : accx_q;
	assign q_s    = axis_q ? pny_q   : pnx_q;
	assign r_s    = axis_q ? mny_q   : mnx_q;
	assign bias_s = axis_q ? biasy_q : biasx_q;

	assign pq_sum  = {1'b0, cov_s} + {1'b0, q_s};
	assign den_sum = {2'b00, pn_q} + {2'b00, r_s};
	assign k_val   = (GAIN_BITS+1)'(1 << GAIN_BITS) - {1'b0, g_q};
	assign prod_hi = SUM_W'($signed(u_prod[PROD_W-1:FRAC]));
	assign vn_sat  = sat_word(SUM_W'(pred_q) + prod_hi);

	always_comb begin
		cmd  = '0;
		op_a = '0;
		op_b = '0;
		case (state_q)
			S_PMUL: begin
				cmd.start = 1'b1;
				cmd.steps = CNT_W'(DT_W);
				op_a      = MCAND_W'(acc_s);
				op_b      = dt_q;
			end
			S_DIV: begin
				cmd.start = (den_sum != '0) && (r_s != '0);
				cmd.div   = 1'b1;
				cmd.steps = CNT_W'(GAIN_BITS);
				op_a      = $signed({2'b00, pn_q});
			end
			S_VMUL: begin
				cmd.start = 1'b1;
				cmd.steps = CNT_W'(GAIN_BITS);
				op_a      = MCAND_W'(diff_q);
				op_b      = MULT_W'(g_q);
			end
			S_CMUL: begin
				cmd.start = 1'b1;
				cmd.steps = CNT_W'(GAIN_BITS + 1);
				op_a      = $signed({2'b00, pn_q});
				op_b      = MULT_W'(k_val);
			end
			default: begin
				cmd = '0;
			end
		endcase
	end

	assign cfg_ready = 1'b1;
	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = out_valid_q;
	assign vel_x_out = outx_q;
	assign vel_y_out = outy_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pnx_q   <= RST_PN;
			pny_q   <= RST_PN;
			mnx_q   <= RST_MN;
			mny_q   <= RST_MN;
			biasx_q <= RST_BIAS_X;
			biasy_q <= RST_BIAS_Y;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_PN_X:   pnx_q   <= cfg_data;
				REG_PN_Y:   pny_q   <= cfg_data;
				REG_MN_X:   mnx_q   <= cfg_data;
				REG_MN_Y:   mny_q   <= cfg_data;
				REG_BIAS_X: biasx_q <= cfg_data;
				REG_BIAS_Y: biasy_q <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			axis_q      <= 1'b0;
			out_valid_q <= 1'b0;
			velx_q      <= '0;
			vely_q      <= '0;
			covx_q      <= '0;
			covy_q      <= '0;
		end else begin
			if (state_q == S_OUT && (!out_valid_q || out_ready))
				out_valid_q <= 1'b1;
			else if (out_valid_q && out_ready)
				out_valid_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						axis_q  <= 1'b0;
						state_q <= S_PMUL;
					end
				end
				S_PMUL: state_q <= S_PWAIT;
				S_PWAIT: begin
					if (u_done)
						state_q <= S_DIV;
				end
				S_DIV: begin
					if (den_sum == '0 || r_s == '0)
						state_q <= S_VMUL;
					else
						state_q <= S_DWAIT;
				end
				S_DWAIT: begin
					if (u_done)
						state_q <= S_VMUL;
				end
				S_VMUL: state_q <= S_VWAIT;
				S_VWAIT: begin
					if (u_done)
						state_q <= S_CMUL;
				end
				S_CMUL: state_q <= S_CWAIT;
				S_CWAIT: begin
					if (u_done) begin
						if (axis_q) begin
							vely_q  <= vn_q;
							covy_q  <= u_prod[FRAC+DATA_W-1:FRAC];
							state_q <= S_OUT;
						end else begin
							velx_q  <= vn_q;
							covx_q  <= u_prod[FRAC+DATA_W-1:FRAC];
							axis_q  <= 1'b1;
							state_q <= S_PMUL;
						end
					end
				end
				S_OUT: begin
					if (!out_valid_q || out_ready)
						state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && in_valid) begin
			flowx_q <= flow_x;
			flowy_q <= flow_y;
			accx_q  <= accel_x;
			accy_q  <= accel_y;
			dt_q    <= time_step;
		end
		if (state_q == S_PWAIT && u_done) begin
			pred_q <= sat_word(SUM_W'(vel_s) + prod_hi);
			pn_q   <= pq_sum[DATA_W] ? '1 : pq_sum[DATA_W-1:0];
		end
		if (state_q == S_DIV) begin
			diff_q <= (DATA_W+1)'(flow_s) - (DATA_W+1)'(pred_q);
			// zero denominator gives zero gain, unit gain is clipped
			if (den_sum == '0)
				g_q <= '0;
			else if (r_s == '0)
				g_q <= GAIN_MAX;
		end
		if (state_q == S_DWAIT && u_done)
			g_q <= u_quo;
		if (state_q == S_VWAIT && u_done)
			vn_q <= vn_sat;
		if (state_q == S_CWAIT && u_done) begin
			if (axis_q)
				resy_q <= sat_word(SUM_W'(vn_q) - SUM_W'(bias_s));
			else
				resx_q <= sat_word(SUM_W'(vn_q) - SUM_W'(bias_s));
		end
		if (state_q == S_OUT && (!out_valid_q || out_ready)) begin
			outx_q <= resx_q;
			outy_q <= resy_q;
		end
	end

endmodule

// ----- rtl/tvk_serial_unit.sv -----
// ----------------------------------------------------------------------------
// tvk_serial_unit
// Shared bit-serial unit: shift-add multiply (one multiplier bit per cycle)
// and restoring divide (one quotient bit per cycle).
// ----------------------------------------------------------------------------
module tvk_serial_unit
	import tvk_pkg::*;
(
	input  logic                       clk,
	input  logic                       arst_n,
	input  tvk_cmd_t                   cmd,
	input  logic signed [MCAND_W-1:0]  a,
	input  logic [MULT_W-1:0]          b,
	input  logic [DIV_W-1:0]           den,
	output logic                       done,
	output logic signed [PROD_W-1:0]   prod,
	output logic [GAIN_BITS-1:0]       quo
);

	logic                      busy_q;
	logic                      div_q;
	logic                      done_q;
	logic [CNT_W-1:0]          cnt_q;
	logic signed [PROD_W-1:0]  mcand_q;
	logic [MULT_W-1:0]         mult_q;
	logic signed [PROD_W-1:0]  acc_q;
	logic [DIV_W-1:0]          rem_q;
	logic [DIV_W-1:0]          den_q;
	logic [GAIN_BITS-1:0]      quo_q;
	logic [DIV_W-1:0]          rem2;

	assign rem2 = {rem_q[DIV_W-2:0], 1'b0};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			div_q  <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (cmd.start) begin
				busy_q <= 1'b1;
				div_q  <= cmd.div;
				cnt_q  <= cmd.steps;
			end else if (busy_q) begin
				cnt_q <= cnt_q - CNT_W'(1);
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.start) begin
			acc_q   <= '0;
			mcand_q <= PROD_W'(a);
			mult_q  <= b;
			rem_q   <= a[DIV_W-1:0];
			den_q   <= den;
			quo_q   <= '0;
		end else if (busy_q) begin
			if (div_q) begin
				// one restoring step per cycle
				if (rem2 >= den_q) begin
					rem_q <= rem2 - den_q;
					quo_q <= {quo_q[GAIN_BITS-2:0], 1'b1};
				end else begin
					rem_q <= rem2;
					quo_q <= {quo_q[GAIN_BITS-2:0], 1'b0};
				end
			end else begin
				if (mult_q[0])
					acc_q <= acc_q + mcand_q;
				mcand_q <= mcand_q <<< 1;
				mult_q  <= mult_q >> 1;
			end
		end
	end

	assign done = done_q;
	assign prod = acc_q;
	assign quo  = quo_q;

endmodule
